### sv/ltg_pkg.sv
// ----------------------------------------------------------------------------
// ltg_pkg
// Shared types and constants for the logging trigger hysteresis gate.
// ----------------------------------------------------------------------------
package ltg_pkg;

    // Field widths
    localparam int RPM_W      = 16;
    localparam int TPS_W      = 7;
    localparam int KPA_W      = 10;
    localparam int KMH_W      = 8;
    localparam int DT_W       = 10;
    localparam int DELAY_W    = 8;
    localparam int TIMER_W    = 18;
    localparam int REASON_W   = 3;

    // Bus widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [9:0]         MS_PER_S  = 10'd1000;

    typedef enum logic [REASON_W-1:0] {
        REASON_UNCOND     = 3'd0,
        REASON_ACTIVE     = 3'd1,
        REASON_BUTTON_OFF = 3'd2,
        REASON_STOP_DELAY = 3'd3,
        REASON_WAIT_GATES = 3'd4,
        REASON_WAIT_SPEED = 3'd5
    } reason_t;

    typedef enum logic [2:0] {
        REG_COND_EN   = 3'd0,
        REG_BTN_PRES  = 3'd1,
        REG_START_RPM = 3'd2,
        REG_STOP_RPM  = 3'd3,
        REG_MIN_TPS   = 3'd4,
        REG_MIN_KPA   = 3'd5,
        REG_MIN_KMH   = 3'd6,
        REG_STOP_DLY  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DT_W-1:0]  elapsed_ms;
        logic             button_level;
        logic [KMH_W-1:0] vehicle_kmh;
        logic [KPA_W-1:0] manifold_kpa;
        logic [TPS_W-1:0] throttle_pct;
        logic [RPM_W-1:0] engine_rpm;
    } tick_t;

endpackage

### sv/log_trigger_hysteresis_gate.sv
// ----------------------------------------------------------------------------
// log_trigger_hysteresis_gate
// Per-tick decision on whether data logging runs, with the reason behind it.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one evaluation tick (speed, throttle, pressure, ...)
//  m_axis   | out       | logging_on and reason code, one per tick
//  APB      | in/out    | eight configuration registers at byte address 4*i
//
//  One request is taken per clock while the output is not stalled. A
//  tick is captured in the input register, then evaluated against the held
//  state and written to the result register, which offers it on m_axis.
//  The state update (flag, button, stop timer) is made as each tick is
//  written there. rst_n clears the state, the configuration and both valid flags.
//  A stalled output holds the result and the input register; requests are
//  still taken while the input register is free or moving on.
//
module log_trigger_hysteresis_gate (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] engine_rpm, [22:16] throttle_pct, [32:23] manifold_kpa,
    // [40:33] vehicle_kmh, [41] button_level, [51:42] elapsed_ms, [55:52] zero
    input  logic [ltg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] logging_on, [3:1] reason, [7:4] zero
    output logic [ltg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ltg_pkg::PADDR_W-1:0]       paddr,
    input  logic [ltg_pkg::PDATA_W-1:0]       pwdata,
    output logic [ltg_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import ltg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               cond_en_reg;
    logic               btn_pres_reg;
    logic [RPM_W-1:0]   start_rpm_reg;
    logic [RPM_W-1:0]   stop_rpm_reg;
    logic [TPS_W-1:0]   min_tps_reg;
    logic [KPA_W-1:0]   min_kpa_reg;
    logic [KMH_W-1:0]   min_kmh_reg;
    logic [DELAY_W-1:0] stop_dly_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_en_reg   <= 1'b0;
            btn_pres_reg  <= 1'b0;
            start_rpm_reg <= '0;
            stop_rpm_reg  <= '0;
            min_tps_reg   <= '0;
            min_kpa_reg   <= '0;
            min_kmh_reg   <= '0;
            stop_dly_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COND_EN:   cond_en_reg   <= pwdata[0];
                REG_BTN_PRES:  btn_pres_reg  <= pwdata[0];
                REG_START_RPM: start_rpm_reg <= pwdata[RPM_W-1:0];
                REG_STOP_RPM:  stop_rpm_reg  <= pwdata[RPM_W-1:0];
                REG_MIN_TPS:   min_tps_reg   <= pwdata[TPS_W-1:0];
                REG_MIN_KPA:   min_kpa_reg   <= pwdata[KPA_W-1:0];
                REG_MIN_KMH:   min_kmh_reg   <= pwdata[KMH_W-1:0];
                REG_STOP_DLY:  stop_dly_reg  <= pwdata[DELAY_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back, zero-extended
    always_comb
    begin
        case (cfg_idx)
            REG_COND_EN:   prdata = {{(PDATA_W-1){1'b0}}, cond_en_reg};
            REG_BTN_PRES:  prdata = {{(PDATA_W-1){1'b0}}, btn_pres_reg};
            REG_START_RPM: prdata = {{(PDATA_W-RPM_W){1'b0}}, start_rpm_reg};
            REG_STOP_RPM:  prdata = {{(PDATA_W-RPM_W){1'b0}}, stop_rpm_reg};
            REG_MIN_TPS:   prdata = {{(PDATA_W-TPS_W){1'b0}}, min_tps_reg};
            REG_MIN_KPA:   prdata = {{(PDATA_W-KPA_W){1'b0}}, min_kpa_reg};
            REG_MIN_KMH:   prdata = {{(PDATA_W-KMH_W){1'b0}}, min_kmh_reg};
            REG_STOP_DLY:  prdata = {{(PDATA_W-DELAY_W){1'b0}}, stop_dly_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic  in_valid_reg;
    tick_t tick_reg;
    logic  out_valid_reg;
    logic  out_free;
    logic  advance;

    // Result register can take a new value when empty or being drained
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            tick_reg <= tick_t'(s_axis_tdata[$bits(tick_t)-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Evaluation of the held tick against the state
    // ------------------------------------------------------------------
    logic               logging_flag_reg;
    logic               last_button_reg;
    logic [TIMER_W-1:0] below_stop_ms_reg;

    logic               logging_flag_next;
    logic               last_button_next;
    logic [TIMER_W-1:0] below_stop_ms_next;
    reason_t            reason_next;

    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_acc;
    logic [TIMER_W-1:0] delay_ms;
    logic [RPM_W-1:0]   stop_thr;
    logic               gates_ok;
    logic               above_start;
    logic               above_stop;

    // Stop timer gains this tick's time in every mode, saturating, unless restarted at speed
    assign timer_sum = {1'b0, below_stop_ms_reg}
                     + {{(TIMER_W+1-DT_W){1'b0}}, tick_reg.elapsed_ms};
    assign timer_acc = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];

    // Seconds to milliseconds; 255 s still fits the timer width
    assign delay_ms = TIMER_W'({{(TIMER_W-DELAY_W){1'b0}}, stop_dly_reg}
                             * {{(TIMER_W-10){1'b0}}, MS_PER_S});

    // Clamp the stop threshold to the start threshold
    assign stop_thr = (stop_rpm_reg >= start_rpm_reg) ? start_rpm_reg : stop_rpm_reg;

    // A zero minimum disables its gate
    assign gates_ok = ((min_tps_reg == '0) || (tick_reg.throttle_pct >= min_tps_reg))
                   && ((min_kpa_reg == '0) || (tick_reg.manifold_kpa >= min_kpa_reg))
                   && ((min_kmh_reg == '0) || (tick_reg.vehicle_kmh >= min_kmh_reg));

    assign above_start = tick_reg.engine_rpm >= start_rpm_reg;
    assign above_stop  = tick_reg.engine_rpm >= stop_thr;

    always_comb
    begin
        logging_flag_next  = logging_flag_reg;
        last_button_next   = last_button_reg;
        below_stop_ms_next = timer_acc;
        reason_next        = REASON_UNCOND;

        if (!cond_en_reg)
        begin
            // Always log
            logging_flag_next = 1'b1;
            reason_next       = REASON_UNCOND;
        end
        else if (btn_pres_reg)
        begin
            // Toggle on a rising edge of the button
            if (tick_reg.button_level && !last_button_reg)
            begin
                logging_flag_next = !logging_flag_reg;
            end
            last_button_next = tick_reg.button_level;
            reason_next      = logging_flag_next ? REASON_ACTIVE : REASON_BUTTON_OFF;
        end
        else
        begin
            // Speed hysteresis: start on threshold plus gates
            if (above_start && gates_ok)
            begin
                logging_flag_next = 1'b1;
            end

            // Restart the stop timer at speed, else stop once the delay runs out
            if (above_stop)
            begin
                below_stop_ms_next = '0;
            end
            else if (timer_acc >= delay_ms)
            begin
                logging_flag_next = 1'b0;
            end

            if (logging_flag_next)
            begin
                reason_next = above_stop ? REASON_ACTIVE : REASON_STOP_DELAY;
            end
            else
            begin
                reason_next = (above_start && !gates_ok) ? REASON_WAIT_GATES
                                                         : REASON_WAIT_SPEED;
            end
        end
    end

    // State moves only when a tick is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logging_flag_reg  <= 1'b0;
            last_button_reg   <= 1'b0;
            below_stop_ms_reg <= '0;
        end
        else if (advance)
        begin
            logging_flag_reg  <= logging_flag_next;
            last_button_reg   <= last_button_next;
            below_stop_ms_reg <= below_stop_ms_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic    logging_on_reg;
    reason_t reason_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            logging_on_reg <= logging_flag_next;
            reason_reg     <= reason_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-REASON_W-1){1'b0}}, reason_reg, logging_on_reg};

endmodule
